### hw/rtl/bss_pkg.sv
// Shared definitions for the buffer substring search block.
// Holds configuration register codes, field widths, the configuration and
// result bundles, and the pattern byte selection function. No dependencies.
package bss_pkg;

  // Default sizes for the top level parameters.
  localparam int BUFFER_BYTES_DEFAULT = 512;
  localparam int MAX_PATTERN_DEFAULT  = 20;
  localparam int ROW_BYTES_DEFAULT    = 32;

  // Pattern storage: three registers holding twenty bytes in total.
  localparam int PATTERN_STORE_BYTES = 20;
  localparam int PATTERN_BITS        = 8 * PATTERN_STORE_BYTES;

  // Configuration port and field widths.
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int LENGTH_W    = 5;
  localparam int START_W     = 10;
  localparam int OFFSET_W    = 9;
  localparam int HEX_W       = 6;
  localparam int ROW_W       = 4;

  // Compare masks for exact and case-folded comparison.
  localparam logic [7:0] EXACT_MASK = 8'hFF;
  localparam logic [7:0] FOLD_MASK  = 8'hDF;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PATTERN_LOW  = 3'd0,
    REG_PATTERN_MID  = 3'd1,
    REG_PATTERN_HIGH = 3'd2,
    REG_LENGTH       = 3'd3,
    REG_MATCH_CASE   = 3'd4,
    REG_START_OFFSET = 3'd5
  } cfg_reg_t;

  // Current configuration as seen by the search logic.
  typedef struct packed {
    logic [PATTERN_BITS-1:0] pattern;
    logic [LENGTH_W-1:0]     length;
    logic                    match_case;
    logic [START_W-1:0]      start_offset;
  } cfg_t;

  // Outcome of one item as computed by the matcher.
  typedef struct packed {
    logic                produce;
    logic                hit;
    logic                found;
    logic [OFFSET_W-1:0] match_offset;
    logic [HEX_W-1:0]    hex_column;
    logic [ROW_W-1:0]    row;
  } result_t;

  // Pattern byte k; bytes beyond the stored twenty read as zero.
  function automatic logic [7:0] pattern_byte(input logic [PATTERN_BITS-1:0] pattern,
                                              input logic [LENGTH_W-1:0] k);
    logic [7:0] b;
    b = 8'd0;
    if (k < LENGTH_W'(PATTERN_STORE_BYTES)) begin
      b = pattern[8*k +: 8];
    end
    return b;
  endfunction

endpackage

### hw/rtl/bss_cfg_regs.sv
// Configuration registers of the buffer substring search block.
// Decodes writes on the configuration channel into the cfg_t bundle.
// Depends on bss_pkg.
module bss_cfg_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bss_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bss_pkg::CFG_DATA_W-1:0]  cfg_data,
  output bss_pkg::cfg_t                   cfg
);

  // Writes are taken in any cycle.
  assign cfg_ready = 1'b1;

  // Register file; indexes outside the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pattern      <= '0;
      cfg.length       <= '0;
      cfg.match_case   <= 1'b1;
      cfg.start_offset <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (bss_pkg::cfg_reg_t'(cfg_index))
        bss_pkg::REG_PATTERN_LOW:  cfg.pattern[63:0]    <= cfg_data;
        bss_pkg::REG_PATTERN_MID:  cfg.pattern[127:64]  <= cfg_data;
        bss_pkg::REG_PATTERN_HIGH: cfg.pattern[159:128] <= cfg_data[31:0];
        bss_pkg::REG_LENGTH:       cfg.length <= cfg_data[bss_pkg::LENGTH_W-1:0];
        bss_pkg::REG_MATCH_CASE:   cfg.match_case <= cfg_data[0];
        bss_pkg::REG_START_OFFSET: cfg.start_offset <= cfg_data[bss_pkg::START_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

### hw/rtl/bss_window.sv
// Sliding window of recent buffer bytes with their row and column, plus the
// position counters and the per-buffer match flag.
// Depends on bss_pkg.
module bss_window #(
  parameter int BUFFER_BYTES = bss_pkg::BUFFER_BYTES_DEFAULT,
  parameter int MAX_PATTERN  = bss_pkg::MAX_PATTERN_DEFAULT,
  parameter int ROW_BYTES    = bss_pkg::ROW_BYTES_DEFAULT,
  localparam int DEPTH = (MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1,
  localparam int POS_W = $clog2(BUFFER_BYTES + 1),
  localparam int COL_W = $clog2(ROW_BYTES)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      step,
  input  logic [7:0]                data_byte,
  input  logic                      last_byte,
  input  logic                      hit,
  output logic [7:0]                recent [DEPTH],
  output logic [COL_W-1:0]          recent_col [DEPTH],
  output logic [bss_pkg::ROW_W-1:0] recent_row [DEPTH],
  output logic [POS_W-1:0]          pos,
  output logic [COL_W-1:0]          col,
  output logic [bss_pkg::ROW_W-1:0] row_cnt,
  output logic                      reported
);

  // Position, row/column of the current byte and the match flag.
  // The end of a buffer starts the next one from position zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      col      <= '0;
      row_cnt  <= '0;
      reported <= 1'b0;
    end else if (step) begin
      if (last_byte) begin
        pos      <= '0;
        col      <= '0;
        row_cnt  <= '0;
        reported <= 1'b0;
      end else begin
        if (hit) begin
          reported <= 1'b1;
        end
        if (pos < POS_W'(BUFFER_BYTES)) begin
          pos <= pos + 1'b1;
          if (col == COL_W'(ROW_BYTES - 1)) begin
            col     <= '0;
            row_cnt <= row_cnt + 1'b1;
          end else begin
            col <= col + 1'b1;
          end
        end
      end
    end
  end

  // Shift line of earlier bytes, newest in entry zero. Entries from an
  // earlier buffer are never compared, so they need no clearing.
  always_ff @(posedge clk) begin
    if (step && !last_byte) begin
      recent[0]     <= data_byte;
      recent_col[0] <= col;
      recent_row[0] <= row_cnt;
      for (int i = 1; i < DEPTH; i++) begin
        recent[i]     <= recent[i-1];
        recent_col[i] <= recent_col[i-1];
        recent_row[i] <= recent_row[i-1];
      end
    end
  end

endmodule

### hw/rtl/bss_match.sv
// Window comparator of the buffer substring search block: compares the
// current byte and the window against the pattern and forms the result.
// Depends on bss_pkg.
module bss_match #(
  parameter int BUFFER_BYTES = bss_pkg::BUFFER_BYTES_DEFAULT,
  parameter int MAX_PATTERN  = bss_pkg::MAX_PATTERN_DEFAULT,
  parameter int ROW_BYTES    = bss_pkg::ROW_BYTES_DEFAULT,
  localparam int DEPTH = (MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1,
  localparam int POS_W = $clog2(BUFFER_BYTES + 1),
  localparam int COL_W = $clog2(ROW_BYTES)
) (
  input  bss_pkg::cfg_t             cfg,
  input  logic                      item_valid,
  input  logic [7:0]                cur_byte,
  input  logic                      cur_last,
  input  logic [7:0]                recent [DEPTH],
  input  logic [COL_W-1:0]          recent_col [DEPTH],
  input  logic [bss_pkg::ROW_W-1:0] recent_row [DEPTH],
  input  logic [POS_W-1:0]          pos,
  input  logic [COL_W-1:0]          col,
  input  logic [bss_pkg::ROW_W-1:0] row_cnt,
  input  logic                      reported,
  output bss_pkg::result_t          res
);

  localparam int CW = POS_W + 1;
  localparam int SW = (CW > bss_pkg::START_W) ? CW : bss_pkg::START_W;
  localparam int LW = bss_pkg::LENGTH_W;

  logic [7:0]                mask;
  logic [LW-1:0]             len;
  logic                      len_ok;
  logic [CW-1:0]             pos_ext;
  logic [CW-1:0]             len_ext;
  logic                      room;
  logic [CW-1:0]             start_pos;
  logic                      start_ok;
  logic                      in_buf;
  logic                      bytes_ok;
  logic [COL_W-1:0]          st_col;
  logic [bss_pkg::ROW_W-1:0] st_row;

  assign mask      = cfg.match_case ? bss_pkg::EXACT_MASK : bss_pkg::FOLD_MASK;
  assign len       = cfg.length;
  assign len_ok    = (len != '0) && (len <= LW'(MAX_PATTERN));
  assign pos_ext   = CW'(pos) + 1'b1;
  assign len_ext   = CW'(len);
  assign room      = pos_ext >= len_ext;
  assign start_pos = pos_ext - len_ext;
  assign start_ok  = SW'(start_pos) >= SW'(cfg.start_offset);
  assign in_buf    = pos < POS_W'(BUFFER_BYTES);

  // Byte comparison: the current byte against the last pattern byte, and
  // window entry i against pattern byte len-2-i for every entry in use.
  always_comb begin
    logic [LW-1:0] idx;
    idx      = '0;
    bytes_ok = ((cur_byte ^ bss_pkg::pattern_byte(cfg.pattern, len - 1'b1)) & mask) == 8'd0;
    for (int i = 0; i < DEPTH; i++) begin
      idx = len - LW'(i) - LW'(2);
      if ((LW'(i) + LW'(1)) < len) begin
        if (((recent[i] ^ bss_pkg::pattern_byte(cfg.pattern, idx)) & mask) != 8'd0) begin
          bytes_ok = 1'b0;
        end
      end
    end
  end

  // Row and column of the first matched byte, taken from the window.
  always_comb begin
    st_col = col;
    st_row = row_cnt;
    for (int i = 0; i < DEPTH; i++) begin
      if ((LW'(i) + LW'(2)) == len) begin
        st_col = recent_col[i];
        st_row = recent_row[i];
      end
    end
  end

  // A result at the first match, or at the last byte when none was found.
  always_comb begin
    res.hit     = item_valid && !reported && in_buf && len_ok && room && start_ok &&
                  bytes_ok;
    res.produce = res.hit || (item_valid && cur_last && !reported);
    res.found   = res.hit;
    if (res.hit) begin
      res.match_offset = bss_pkg::OFFSET_W'(start_pos);
      res.hex_column   = bss_pkg::HEX_W'({st_col, 1'b0});
      res.row          = st_row;
    end else begin
      res.match_offset = '0;
      res.hex_column   = '0;
      res.row          = '0;
    end
  end

endmodule

### hw/rtl/buffer_substring_search_top.sv
// Top level of the buffer substring search block.
// Instantiates bss_cfg_regs, bss_window and bss_match; depends on bss_pkg.
//
// The block scans a buffer one byte per item and reports the first place,
// at or after start_offset, where the configured pattern of up to
// MAX_PATTERN bytes starts, with the whole match inside the first
// BUFFER_BYTES bytes. Each buffer gives exactly one result item: at the
// first match, or at the byte marked last_byte when nothing matched. One
// item is accepted every clock cycle while in_stall is low; an item sits
// in the input register while all pattern bytes are compared in parallel
// against the window of earlier bytes, and its result is then written to
// the output register. in_stall rises only when a result item is still
// waiting in the output register and the item in the input register would
// produce another one. Configuration must be written by the user only
// while no item is in flight; the block itself does not enforce this.
module buffer_substring_search_top #(
  parameter int BUFFER_BYTES = bss_pkg::BUFFER_BYTES_DEFAULT,
  parameter int MAX_PATTERN  = bss_pkg::MAX_PATTERN_DEFAULT,
  parameter int ROW_BYTES    = bss_pkg::ROW_BYTES_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  // Configuration channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bss_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bss_pkg::CFG_DATA_W-1:0]  cfg_data,
  // Input items
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      data_byte,
  input  logic                            last_byte,
  // Result items
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            found,
  output logic [bss_pkg::OFFSET_W-1:0]    match_offset,
  output logic [bss_pkg::HEX_W-1:0]       hex_column,
  output logic [bss_pkg::ROW_W-1:0]       row
);

  localparam int DEPTH = (MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1;
  localparam int POS_W = $clog2(BUFFER_BYTES + 1);
  localparam int COL_W = $clog2(ROW_BYTES);

  bss_pkg::cfg_t             cfg;
  bss_pkg::result_t          res;
  logic                      in_full;
  logic [7:0]                cur_byte;
  logic                      cur_last;
  logic                      advance;
  logic [7:0]                recent [DEPTH];
  logic [COL_W-1:0]          recent_col [DEPTH];
  logic [bss_pkg::ROW_W-1:0] recent_row [DEPTH];
  logic [POS_W-1:0]          pos;
  logic [COL_W-1:0]          col;
  logic [bss_pkg::ROW_W-1:0] row_cnt;
  logic                      reported;

  bss_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // The item in the input register moves on unless it would produce a
  // result while the output register is still held.
  assign advance  = in_full && (!res.produce || !out_valid || !out_stall);
  assign in_stall = in_full && !advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      cur_byte <= data_byte;
      cur_last <= last_byte;
    end
  end

  bss_window #(
    .BUFFER_BYTES (BUFFER_BYTES),
    .MAX_PATTERN  (MAX_PATTERN),
    .ROW_BYTES    (ROW_BYTES)
  ) u_window (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .data_byte  (cur_byte),
    .last_byte  (cur_last),
    .hit        (res.hit),
    .recent     (recent),
    .recent_col (recent_col),
    .recent_row (recent_row),
    .pos        (pos),
    .col        (col),
    .row_cnt    (row_cnt),
    .reported   (reported)
  );

  bss_match #(
    .BUFFER_BYTES (BUFFER_BYTES),
    .MAX_PATTERN  (MAX_PATTERN),
    .ROW_BYTES    (ROW_BYTES)
  ) u_match (
    .cfg        (cfg),
    .item_valid (in_full),
    .cur_byte   (cur_byte),
    .cur_last   (cur_last),
    .recent     (recent),
    .recent_col (recent_col),
    .recent_row (recent_row),
    .pos        (pos),
    .col        (col),
    .row_cnt    (row_cnt),
    .reported   (reported),
    .res        (res)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && res.produce) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.produce) begin
      found        <= res.found;
      match_offset <= res.match_offset;
      hex_column   <= res.hex_column;
      row          <= res.row;
    end
  end

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for buffer_substring_search_top: a scripted warm-up
// followed by randomised buffers checked against an in-bench search model.
// Depends on bss_pkg and the RTL of the block only.
module tb_top;
  import bss_pkg::*;

  localparam int SCRIPT_ROWS     = 28;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 80;
  localparam int LONG_BUF_MAX    = 600;
  localparam int SETTLE_CYCLES   = 6;
  localparam int WATCHDOG_LIMIT  = 1000;
  localparam int REPORT_LIMIT    = 10;
  localparam logic [7:0] CASE_BIT = 8'h20;
  localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = 3'd7;

  typedef struct packed {
    logic                found;
    logic [OFFSET_W-1:0] offset;
    logic [HEX_W-1:0]    column;
    logic [ROW_W-1:0]    row_idx;
  } search_result_t;

  localparam search_result_t NONE_FOUND = '0;

  // One scripted step: either a register write or a byte of a buffer.
  typedef struct packed {
    logic                   is_write;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  value;
    logic                   last;
    logic                   typed;
    search_result_t         want;
  } script_step_t;

  // Pattern "Ab" is used throughout; the expected result is typed in where obvious.
  localparam script_step_t SCRIPT [SCRIPT_ROWS] = '{
    '{1'b0, '0, 64'h00, 1'b0, 1'b0, NONE_FOUND},
    '{1'b0, '0, 64'hFF, 1'b1, 1'b1, NONE_FOUND},
    '{1'b1, REG_PATTERN_LOW, 64'h6241, 1'b0, 1'b0, NONE_FOUND},
    '{1'b1, REG_LENGTH, 64'd2, 1'b0, 1'b0, NONE_FOUND},
    '{1'b1, REG_MATCH_CASE, 64'd0, 1'b0, 1'b0, NONE_FOUND},
    '{1'b0, '0, 64'h61, 1'b0, 1'b0, NONE_FOUND},
    '{1'b0, '0, 64'h42, 1'b0, 1'b1, '{1'b1, 9'd0, 6'd0, 4'd0}},
    '{1'b0, '0, 64'h41, 1'b0, 1'b0, NONE_FOUND},
    '{1'b0, '0, 64'h62, 1'b1, 1'b0, NONE_FOUND},
    '{1'b0, '0, 64'h78, 1'b0, 1'b0, NONE_FOUND},
    '{1'b0, '0, 64'h41, 1'b0, 1'b0, NONE_FOUND},
    '{1'b0, '0, 64'h62, 1'b1, 1'b1, '{1'b1, 9'd1, 6'd2, 4'd0}},
    '{1'b1, REG_MATCH_CASE, 64'd1, 1'b0, 1'b0, NONE_FOUND},
    '{1'b0, '0, 64'h61, 1'b0, 1'b0, NONE_FOUND},
    '{1'b0, '0, 64'h42, 1'b1, 1'b1, NONE_FOUND},
    '{1'b1, REG_START_OFFSET, 64'd512, 1'b0, 1'b0, NONE_FOUND},
    '{1'b0, '0, 64'h41, 1'b0, 1'b0, NONE_FOUND},
    '{1'b0, '0, 64'h62, 1'b1, 1'b1, NONE_FOUND},
    '{1'b1, REG_START_OFFSET, 64'd0, 1'b0, 1'b0, NONE_FOUND},
    '{1'b1, REG_PATTERN_MID, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, NONE_FOUND},
    '{1'b1, REG_PATTERN_HIGH, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, NONE_FOUND},
    '{1'b1, REG_LENGTH, 64'd31, 1'b0, 1'b0, NONE_FOUND},
    '{1'b0, '0, 64'h41, 1'b0, 1'b0, NONE_FOUND},
    '{1'b0, '0, 64'h62, 1'b1, 1'b1, NONE_FOUND},
    '{1'b1, REG_UNMAPPED, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, NONE_FOUND},
    '{1'b1, REG_LENGTH, 64'd2, 1'b0, 1'b0, NONE_FOUND},
    '{1'b0, '0, 64'h41, 1'b0, 1'b0, NONE_FOUND},
    '{1'b0, '0, 64'h62, 1'b1, 1'b1, '{1'b1, 9'd0, 6'd0, 4'd0}}
  };

  // Clock, reset and block ports.
  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [7:0]             data_byte = 8'h00;
  logic                   last_byte = 1'b0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic                   found;
  logic [OFFSET_W-1:0]    match_offset;
  logic [HEX_W-1:0]       hex_column;
  logic [ROW_W-1:0]       row;

  // Search model state and its copy of the configuration, at reset values.
  logic [63:0]         pat_lo = '0;
  logic [63:0]         pat_mid = '0;
  logic [31:0]         pat_hi = '0;
  logic [LENGTH_W-1:0] pat_len = '0;
  logic                exact_cmp = 1'b1;
  logic [START_W-1:0]  first_pos = '0;
  logic [7:0]          history [MAX_PATTERN_DEFAULT-1] = '{default: '0};
  logic [START_W-1:0]  scan_pos = '0;
  logic                hit_sent = 1'b0;

  search_result_t pending_results [$];
  int mismatches = 0;
  int quiet_cycles = 0;
  int gap_pct = 0;
  int stall_pct = 0;

  buffer_substring_search_top dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .data_byte(data_byte), .last_byte(last_byte),
    .out_valid(out_valid), .out_stall(out_stall), .found(found),
    .match_offset(match_offset), .hex_column(hex_column), .row(row)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Pattern byte k of the configured pattern; bytes past the store read as zero.
  function automatic logic [7:0] pattern_at(input int k);
    logic [PATTERN_BITS-1:0] whole;
    whole = {pat_hi, pat_mid, pat_lo};
    return (k < PATTERN_STORE_BYTES) ? whole[8*k +: 8] : 8'h00;
  endfunction

  // Advances the search model by one byte; returns 1 when a result item is due.
  function automatic logic scan_byte(input logic [7:0] b, input logic l,
                                     output search_result_t r);
    logic [7:0] mask;
    logic       hit;
    logic       emit;
    int         pos;
    int         len;
    int         s;
    int         k;
    mask = exact_cmp ? EXACT_MASK : FOLD_MASK;
    pos  = int'(scan_pos);
    len  = int'(pat_len);
    emit = 1'b0;
    r    = NONE_FOUND;
    if (!hit_sent && pos < BUFFER_BYTES_DEFAULT && len >= 1 && len <= MAX_PATTERN_DEFAULT &&
        pos + 1 >= len) begin
      s = pos + 1 - len;
      if (s >= int'(first_pos)) begin
        // The newest byte closes the window; earlier bytes come from the history.
        hit = (b & mask) == (pattern_at(len - 1) & mask);
        for (k = 0; k < len - 1; k++) begin
          if ((history[len - 2 - k] & mask) != (pattern_at(k) & mask)) hit = 1'b0;
        end
        if (hit) begin
          r.found   = 1'b1;
          r.offset  = OFFSET_W'(s);
          r.column  = HEX_W'(2 * (s % ROW_BYTES_DEFAULT));
          r.row_idx = ROW_W'(s / ROW_BYTES_DEFAULT);
          hit_sent  = 1'b1;
          emit      = 1'b1;
        end
      end
    end
    if (l) begin
      // End of buffer: report a miss if nothing was found, then start afresh.
      if (!hit_sent) emit = 1'b1;
      history  = '{default: '0};
      scan_pos = '0;
      hit_sent = 1'b0;
    end else begin
      for (k = MAX_PATTERN_DEFAULT - 2; k >= 1; k--) history[k] = history[k - 1];
      history[0] = b;
      if (scan_pos < START_W'(BUFFER_BYTES_DEFAULT)) scan_pos = scan_pos + 1'b1;
    end
    return emit;
  endfunction

  // Offers one item, with random gaps beforehand, and records what it should cause.
  task automatic send_byte(input logic [7:0] b, input logic l, input logic typed,
                           input search_result_t want);
    search_result_t got;
    while (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    last_byte <= l;
    do @(posedge clk); while (in_stall);
    if (scan_byte(b, l, got) || typed) pending_results.push_back(typed ? want : got);
  endtask

  // Writes one register and mirrors it in the model.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_PATTERN_LOW:  pat_lo = val;
      REG_PATTERN_MID:  pat_mid = val;
      REG_PATTERN_HIGH: pat_hi = val[31:0];
      REG_LENGTH:       pat_len = val[LENGTH_W-1:0];
      REG_MATCH_CASE:   exact_cmp = val[0];
      REG_START_OFFSET: first_pos = val[START_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Holds the sender back until every result has arrived and the pipeline is empty.
  task automatic settle;
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Chooses a new configuration; the first phases and the last one take extremes.
  task automatic pick_settings(input int phase);
    logic [PATTERN_BITS-1:0] pat;
    logic [LENGTH_W-1:0]     len;
    logic                    exact;
    logic [START_W-1:0]      start;
    logic [7:0]              b;
    int                      k;
    int                      pick;
    for (k = 0; k < PATTERN_STORE_BYTES; k++) begin
      if (phase == 0) b = 8'hFF;
      else if (phase == 1) b = 8'h00;
      else if ($urandom_range(0, 1)) b = 8'($urandom);
      else b = (8'h41 + 8'($urandom_range(0, 25))) | ($urandom_range(0, 1) ? CASE_BIT : 8'h00);
      pat[8*k +: 8] = b;
    end
    pick = $urandom_range(0, 19);
    if (phase == 0) len = LENGTH_W'(MAX_PATTERN_DEFAULT);
    else if (phase == 1) len = LENGTH_W'(1);
    else if (pick == 0) len = '0;
    else if (pick == 1) len = LENGTH_W'($urandom_range(MAX_PATTERN_DEFAULT + 1, 31));
    else if (pick == 2) len = LENGTH_W'(MAX_PATTERN_DEFAULT);
    else len = LENGTH_W'($urandom_range(2, 8));
    exact = (phase == 0) ? 1'b1 : (phase == 1) ? 1'b0 : 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 9);
    if (phase == PHASES - 1) start = '1;
    else if (pick == 0) start = START_W'($urandom_range(480, BUFFER_BYTES_DEFAULT));
    else start = START_W'($urandom_range(0, 24));
    // Unused upper data bits carry noise to check that they are ignored.
    write_reg(REG_PATTERN_LOW, pat[63:0]);
    write_reg(REG_PATTERN_MID, pat[127:64]);
    write_reg(REG_PATTERN_HIGH, {32'($urandom), pat[159:128]});
    write_reg(REG_LENGTH, {59'({$urandom, $urandom}), len});
    write_reg(REG_MATCH_CASE, {63'({$urandom, $urandom}), exact});
    write_reg(REG_START_OFFSET, {54'({$urandom, $urandom}), start});
  endtask

  // Sends one buffer: noise, for a short buffer drawn partly from the pattern, mostly with a planted copy.
  task automatic run_buffer(input int blen, input logic long_one);
    logic [7:0] content [LONG_BUF_MAX];
    logic [7:0] b;
    int         len;
    int         at;
    int         k;
    len = int'(pat_len);
    for (k = 0; k < blen; k++) begin
      if (!long_one && $urandom_range(0, 1)) begin
        b = pattern_at($urandom_range(0, PATTERN_STORE_BYTES - 1));
        if ($urandom_range(0, 1)) b = b ^ CASE_BIT;
        content[k] = b;
      end else begin
        content[k] = 8'($urandom);
      end
    end
    if (len >= 1 && len <= MAX_PATTERN_DEFAULT && len <= blen && $urandom_range(0, 3) != 0) begin
      at = long_one ? $urandom_range(blen - 60, blen - len) : $urandom_range(0, blen - len);
      for (k = 0; k < len; k++) begin
        b = pattern_at(k);
        if (!exact_cmp && $urandom_range(0, 1)) b = b ^ CASE_BIT;
        content[at + k] = b;
      end
      // Now and then the copy is spoilt by a single flipped bit.
      if ($urandom_range(0, 3) == 0)
        content[at + $urandom_range(0, len - 1)] ^= 8'h01 << $urandom_range(0, 7);
    end
    for (k = 0; k < blen; k++) send_byte(content[k], k == blen - 1, 1'b0, NONE_FOUND);
  endtask

  // Result checker and random back-pressure.
  always @(posedge clk) begin
    search_result_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("unexpected result item: found=%0d offset=%0d column=%0d row=%0d",
                     found, match_offset, hex_column, row);
        end else begin
          want = pending_results.pop_front();
          if (want.found !== found || want.offset !== match_offset ||
              want.column !== hex_column || want.row_idx !== row) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display("result mismatch: expected %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
                       want.found, want.offset, want.column, want.row_idx,
                       found, match_offset, hex_column, row);
          end
        end
      end
      out_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Watchdog: ends the run when no channel has moved for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus: reset, the scripted steps, then randomised phases.
  initial begin
    int i;
    int phase;
    int sent;
    int blen;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (i = 0; i < SCRIPT_ROWS; i++) begin
      if (SCRIPT[i].is_write) begin
        settle();
        write_reg(SCRIPT[i].index, SCRIPT[i].value);
      end else begin
        send_byte(SCRIPT[i].value[7:0], SCRIPT[i].last, SCRIPT[i].typed, SCRIPT[i].want);
      end
    end

    for (phase = 0; phase < PHASES; phase++) begin
      settle();
      pick_settings(phase);
      // Idling pattern: none, sender gaps, receiver stalls, then both.
      case (phase % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 49; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 49; end
        default: begin gap_pct = 34; stall_pct = 34; end
      endcase
      // One long buffer of 500 to 540 bytes, around the end of the search range, with any copy near its end.
      if (phase == 0) run_buffer($urandom_range(500, 540), 1'b1);
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        blen = $urandom_range(1, 40);
        run_buffer(blen, 1'b0);
        sent += blen;
      end
    end

    settle();
    mismatches += pending_results.size();
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
